// ===== rtl/bats_pkg.sv =====
// Shared types and constants of the bilinear alpha texture sampler.
`timescale 1ns / 1ps

package bats_pkg;

  // Fixed port widths
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int DIM_CFG_W   = 9;
  localparam int TEX_IDX_W   = 16;
  localparam int TEX_VAL_W   = 16;
  localparam int COORD_W     = 19;
  localparam int ALPHA_W     = 16;

  // Item modes
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_PRESENT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_ALPHA = 4'd3;

  // Control bits that travel with a word from the address stages to the store
  typedef struct packed {
    logic valid;
    logic sample;
    logic wr_ok;
  } bats_tag_t;

endpackage

// ===== rtl/bats_ram.sv =====
// Generic one-write, two-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module bats_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write one entry, read two; hold read data while re_i is low
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== rtl/bats_addr.sv =====
// Coordinate clamp, scaling and texel address generation (two stages).
`timescale 1ns / 1ps

module bats_addr #(
  parameter int MAX_SIDE   = 256,
  parameter int FRAC_BITS  = 16,
  parameter int TEXEL_BITS = 16,
  localparam int DW = $clog2(MAX_SIDE + 1),
  localparam int IW = $clog2(MAX_SIDE),
  localparam int AW = $clog2(MAX_SIDE * MAX_SIDE)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [bats_pkg::TEX_IDX_W-1:0]    texel_index_i,
  input  logic [bats_pkg::TEX_VAL_W-1:0]    texel_value_i,
  input  logic [bats_pkg::COORD_W-1:0]      coord_u_i,
  input  logic [bats_pkg::COORD_W-1:0]      coord_v_i,
  input  logic [DW-1:0]                     width_i,
  input  logic [DW-1:0]                     height_i,
  input  logic                              adv_i,
  output bats_pkg::bats_tag_t               tag_o,
  output logic [AW-1:0]                     addr00_o,
  output logic [AW-1:0]                     addr01_o,
  output logic [AW-1:0]                     addr10_o,
  output logic [AW-1:0]                     addr11_o,
  output logic [FRAC_BITS-1:0]              fx_o,
  output logic [FRAC_BITS-1:0]              fy_o,
  output logic [AW-1:0]                     waddr_o,
  output logic [TEXEL_BITS-1:0]             wdata_o
);

  import bats_pkg::*;

  localparam int F     = FRAC_BITS;
  localparam int CW    = F + 1;
  localparam int PW    = CW + IW;
  localparam int RW    = IW + DW;
  localparam int MW    = (CW > COORD_W - 1) ? CW : COORD_W - 1;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam logic [MW-1:0] ONE_M = {{(MW-1){1'b0}}, 1'b1} << F;

  // Clamp a signed coordinate to zero..one
  function automatic logic [CW-1:0] clamp_coord(input logic [COORD_W-1:0] raw);
    logic [MW-1:0] v;
    v = MW'(raw[COORD_W-2:0]);
    if (raw[COORD_W-1]) begin
      v = '0;
    end else if (v > ONE_M) begin
      v = ONE_M;
    end
    return v[CW-1:0];
  endfunction

  // Split a scaled position into floor, ceiling and fraction
  function automatic logic [2*IW+F-1:0] axis_f(input logic [PW-1:0] p,
                                               input logic [IW-1:0] lim);
    logic [IW:0]  f0;
    logic [IW:0]  f1;
    logic [F-1:0] fr;
    f0 = p[F +: IW+1];
    fr = p[F-1:0];
    f1 = f0 + {{IW{1'b0}}, (fr != '0)};
    if (f0 > {1'b0, lim}) begin
      f0 = {1'b0, lim};
    end
    if (f1 > {1'b0, lim}) begin
      f1 = {1'b0, lim};
    end
    if (f1 == f0) begin
      fr = '0;
    end
    return {f0[IW-1:0], f1[IW-1:0], fr};
  endfunction

  logic [IW-1:0] wm1;
  logic [IW-1:0] hm1;
  logic          en1;
  logic          en2;

  assign wm1 = IW'(width_i - DW'(1));
  assign hm1 = IW'(height_i - DW'(1));

  // Stage 1: scale clamped coordinates by dimension minus one
  logic [PW-1:0] pu_d;
  logic [PW-1:0] pv_d;
  logic          v1_q;
  logic          sample1_q;
  logic          wok1_q;
  logic [AW-1:0] widx1_q;
  logic [TEXEL_BITS-1:0] wval1_q;
  logic [PW-1:0] pu1_q;
  logic [PW-1:0] pv1_q;

  assign pu_d = PW'(clamp_coord(coord_u_i)) * PW'(wm1);
  assign pv_d = PW'(clamp_coord(coord_v_i)) * PW'(hm1);

  // Stage 2: floor and ceiling per axis, row base and texel addresses
  logic [IW-1:0] x1;
  logic [IW-1:0] x2;
  logic [IW-1:0] y1;
  logic [IW-1:0] y2;
  logic [F-1:0]  fx;
  logic [F-1:0]  fy;
  logic [IW+DW-1:0] row1;
  logic [IW+DW-1:0] row2;
  bats_tag_t     tag2_q;
  logic [AW-1:0] a00_q;
  logic [AW-1:0] a01_q;
  logic [AW-1:0] a10_q;
  logic [AW-1:0] a11_q;
  logic [F-1:0]  fx2_q;
  logic [F-1:0]  fy2_q;
  logic [AW-1:0] waddr2_q;
  logic [TEXEL_BITS-1:0] wdata2_q;

  assign {x1, x2, fx} = axis_f(pu1_q, wm1);
  assign {y1, y2, fy} = axis_f(pv1_q, hm1);
  assign row1 = RW'(y1) * RW'(width_i);
  assign row2 = RW'(y2) * RW'(width_i);

  // Fill bubbles: a stage loads when empty or when its word moves on
  assign en2 = !tag2_q.valid || adv_i;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      tag2_q <= '0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        tag2_q.valid  <= v1_q;
        tag2_q.sample <= sample1_q;
        tag2_q.wr_ok  <= wok1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      sample1_q <= (mode_i == MODE_SAMPLE);
      wok1_q    <= (32'(texel_index_i) < 32'(DEPTH));
      widx1_q   <= AW'(texel_index_i);
      wval1_q   <= TEXEL_BITS'(texel_value_i);
      pu1_q     <= pu_d;
      pv1_q     <= pv_d;
    end
    if (en2) begin
      a00_q    <= row1[AW-1:0] + AW'(x1);
      a01_q    <= row1[AW-1:0] + AW'(x2);
      a10_q    <= row2[AW-1:0] + AW'(x1);
      a11_q    <= row2[AW-1:0] + AW'(x2);
      fx2_q    <= fx;
      fy2_q    <= fy;
      waddr2_q <= widx1_q;
      wdata2_q <= wval1_q;
    end
  end

  assign tag_o    = tag2_q;
  assign addr00_o = a00_q;
  assign addr01_o = a01_q;
  assign addr10_o = a10_q;
  assign addr11_o = a11_q;
  assign fx_o     = fx2_q;
  assign fy_o     = fy2_q;
  assign waddr_o  = waddr2_q;
  assign wdata_o  = wdata2_q;

endmodule

// ===== rtl/bats_filter.sv =====
// Bilinear blend of four texels and output register (four stages).
`timescale 1ns / 1ps

module bats_filter #(
  parameter int TEXEL_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [TEXEL_BITS-1:0]         t00_i,
  input  logic [TEXEL_BITS-1:0]         t01_i,
  input  logic [TEXEL_BITS-1:0]         t10_i,
  input  logic [TEXEL_BITS-1:0]         t11_i,
  input  logic [FRAC_BITS-1:0]          fx_i,
  input  logic [FRAC_BITS-1:0]          fy_i,
  input  logic                          map_present_i,
  input  logic [bats_pkg::ALPHA_W-1:0]  object_alpha_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bats_pkg::ALPHA_W-1:0]  alpha_o
);

  import bats_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int TB = TEXEL_BITS;
  localparam int HW = F + 1 + TB;
  localparam logic [F:0]  ONE_W  = {1'b1, {F{1'b0}}};
  localparam logic [HW:0] HALF_S = {{HW{1'b0}}, 1'b1} << (F - 1);

  logic en4;
  logic en5;
  logic en6;
  logic en7;
  logic v4_q;
  logic v5_q;
  logic v6_q;
  logic v7_q;

  // Stage 4: horizontal weight products
  logic [F:0]    wx0;
  logic [HW-1:0] h00_d;
  logic [HW-1:0] h01_d;
  logic [HW-1:0] h10_d;
  logic [HW-1:0] h11_d;
  logic [HW-1:0] h00_q;
  logic [HW-1:0] h01_q;
  logic [HW-1:0] h10_q;
  logic [HW-1:0] h11_q;
  logic [F-1:0]  fy4_q;

  assign wx0   = ONE_W - {1'b0, fx_i};
  assign h00_d = HW'(wx0) * HW'(t00_i);
  assign h01_d = HW'(fx_i) * HW'(t01_i);
  assign h10_d = HW'(wx0) * HW'(t10_i);
  assign h11_d = HW'(fx_i) * HW'(t11_i);

  // Stage 5: round the two row blends
  logic [HW:0]   s1;
  logic [HW:0]   s2;
  logic [TB-1:0] r1_q;
  logic [TB-1:0] r2_q;
  logic [F-1:0]  fy5_q;

  assign s1 = {1'b0, h00_q} + {1'b0, h01_q} + HALF_S;
  assign s2 = {1'b0, h10_q} + {1'b0, h11_q} + HALF_S;

  // Stage 6: vertical weight products
  logic [F:0]    wy0;
  logic [HW-1:0] q0_d;
  logic [HW-1:0] q1_d;
  logic [HW-1:0] q0_q;
  logic [HW-1:0] q1_q;

  assign wy0  = ONE_W - {1'b0, fy5_q};
  assign q0_d = HW'(wy0) * HW'(r1_q);
  assign q1_d = HW'(fy5_q) * HW'(r2_q);

  // Stage 7: round, saturate, pick object alpha when no map
  logic [HW:0]        sv;
  logic [TB-1:0]      res;
  logic [31:0]        res32;
  logic [ALPHA_W-1:0] sat;
  logic [ALPHA_W-1:0] alpha_d;
  logic [ALPHA_W-1:0] alpha7_q;

  assign sv      = {1'b0, q0_q} + {1'b0, q1_q} + HALF_S;
  assign res     = sv[F +: TB];
  assign res32   = 32'(res);
  assign sat     = (res32 > 32'd65535) ? {ALPHA_W{1'b1}} : res32[ALPHA_W-1:0];
  assign alpha_d = map_present_i ? sat : object_alpha_i;

  // Advance each stage when empty or when its word moves on
  assign en7 = !v7_q || !out_stall_i;
  assign en6 = !v6_q || en7;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign in_ready_o = en4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en4) begin
        v4_q <= in_valid_i;
      end
      if (en5) begin
        v5_q <= v4_q;
      end
      if (en6) begin
        v6_q <= v5_q;
      end
      if (en7) begin
        v7_q <= v6_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      h00_q <= h00_d;
      h01_q <= h01_d;
      h10_q <= h10_d;
      h11_q <= h11_d;
      fy4_q <= fy_i;
    end
    if (en5) begin
      r1_q  <= s1[F +: TB];
      r2_q  <= s2[F +: TB];
      fy5_q <= fy4_q;
    end
    if (en6) begin
      q0_q <= q0_d;
      q1_q <= q1_d;
    end
    if (en7) begin
      alpha7_q <= alpha_d;
    end
  end

  assign out_valid_o = v7_q;
  assign alpha_o     = alpha7_q;

endmodule

// ===== rtl/bilinear_alpha_texture_sampler_core.sv =====
// Top level of the bilinear alpha texture sampler.
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+----------------------------------------
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/in_stall_o   | mode_i, texel_index_i, texel_value_i,
//          |           |                       | coord_u_i, coord_v_i
//  out     | out       | out_valid_o/out_stall_i | alpha_o
//
// One word is taken per cycle while in_stall_o is low. A sample word passes
// through two address stages, one read of the paired texel RAMs (two read
// ports each, one per row), and four blend stages. Write words end at the RAM.
// Reset sets the configuration to its defaults and clears all stage valid bits;
// the texel store is not cleared. Stages fill bubbles, so input words keep being
// taken while the output holds a word, until every stage is occupied.
`timescale 1ns / 1ps

module bilinear_alpha_texture_sampler_core #(
  parameter int MAX_SIDE   = 256,
  parameter int TEXEL_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bats_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bats_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                mode_i,
  input  logic [bats_pkg::TEX_IDX_W-1:0]      texel_index_i,
  input  logic [bats_pkg::TEX_VAL_W-1:0]      texel_value_i,
  input  logic signed [bats_pkg::COORD_W-1:0] coord_u_i,
  input  logic signed [bats_pkg::COORD_W-1:0] coord_v_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bats_pkg::ALPHA_W-1:0]        alpha_o
);

  import bats_pkg::*;

  localparam int DW    = $clog2(MAX_SIDE + 1);
  localparam int CDW   = (DW > DIM_CFG_W) ? DW : DIM_CFG_W;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [CDW-1:0] MS_C = CDW'(MAX_SIDE);

  // Configuration registers
  logic                 map_present_q;
  logic [DIM_CFG_W-1:0] tex_width_q;
  logic [DIM_CFG_W-1:0] tex_height_q;
  logic [ALPHA_W-1:0]   object_alpha_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_present_q  <= 1'b0;
      tex_width_q    <= DIM_CFG_W'(1);
      tex_height_q   <= DIM_CFG_W'(1);
      object_alpha_q <= {ALPHA_W{1'b1}};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAP_PRESENT:  map_present_q  <= cfg_data_i[0];
        CFG_TEX_WIDTH:    tex_width_q    <= cfg_data_i[DIM_CFG_W-1:0];
        CFG_TEX_HEIGHT:   tex_height_q   <= cfg_data_i[DIM_CFG_W-1:0];
        CFG_OBJECT_ALPHA: object_alpha_q <= cfg_data_i[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp dimensions to 1..MAX_SIDE
  function automatic logic [DW-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] d);
    logic [CDW-1:0] e;
    e = CDW'(d);
    if (e == '0) begin
      e = CDW'(1);
    end else if (e > MS_C) begin
      e = MS_C;
    end
    return e[DW-1:0];
  endfunction

  logic [DW-1:0] width_c;
  logic [DW-1:0] height_c;

  assign width_c  = clamp_dim(tex_width_q);
  assign height_c = clamp_dim(tex_height_q);

  // Address stages
  logic                  addr_ready;
  logic                  en3;
  bats_tag_t             tag2;
  logic [AW-1:0]         a00;
  logic [AW-1:0]         a01;
  logic [AW-1:0]         a10;
  logic [AW-1:0]         a11;
  logic [FRAC_BITS-1:0]  fx2;
  logic [FRAC_BITS-1:0]  fy2;
  logic [AW-1:0]         waddr2;
  logic [TEXEL_BITS-1:0] wdata2;

  assign in_stall_o = !addr_ready;

  bats_addr #(
    .MAX_SIDE   (MAX_SIDE),
    .FRAC_BITS  (FRAC_BITS),
    .TEXEL_BITS (TEXEL_BITS)
  ) u_addr (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (addr_ready),
    .mode_i        (mode_i),
    .texel_index_i (texel_index_i),
    .texel_value_i (texel_value_i),
    .coord_u_i     (coord_u_i),
    .coord_v_i     (coord_v_i),
    .width_i       (width_c),
    .height_i      (height_c),
    .adv_i         (en3),
    .tag_o         (tag2),
    .addr00_o      (a00),
    .addr01_o      (a01),
    .addr10_o      (a10),
    .addr11_o      (a11),
    .fx_o          (fx2),
    .fy_o          (fy2),
    .waddr_o       (waddr2),
    .wdata_o       (wdata2)
  );

  // Stage 3: texel store read or write; drop write words here
  logic                  filt_ready;
  logic                  ram_we;
  logic                  v3_q;
  logic [FRAC_BITS-1:0]  fx3_q;
  logic [FRAC_BITS-1:0]  fy3_q;
  logic [TEXEL_BITS-1:0] t00;
  logic [TEXEL_BITS-1:0] t01;
  logic [TEXEL_BITS-1:0] t10;
  logic [TEXEL_BITS-1:0] t11;

  assign en3    = !v3_q || filt_ready;
  assign ram_we = en3 && tag2.valid && !tag2.sample && tag2.wr_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= tag2.valid && tag2.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      fx3_q <= fx2;
      fy3_q <= fy2;
    end
  end

  // Two copies of the store, one per texel row, written alike
  bats_ram #(
    .WIDTH (TEXEL_BITS),
    .DEPTH (DEPTH)
  ) u_ram_top (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (waddr2),
    .wdata_i   (wdata2),
    .re_i      (en3),
    .raddr_a_i (a00),
    .raddr_b_i (a01),
    .rdata_a_o (t00),
    .rdata_b_o (t01)
  );

  bats_ram #(
    .WIDTH (TEXEL_BITS),
    .DEPTH (DEPTH)
  ) u_ram_bot (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (waddr2),
    .wdata_i   (wdata2),
    .re_i      (en3),
    .raddr_a_i (a10),
    .raddr_b_i (a11),
    .rdata_a_o (t10),
    .rdata_b_o (t11)
  );

  // Blend stages and output register
  bats_filter #(
    .TEXEL_BITS (TEXEL_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_filter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (v3_q),
    .in_ready_o     (filt_ready),
    .t00_i          (t00),
    .t01_i          (t01),
    .t10_i          (t10),
    .t11_i          (t11),
    .fx_i           (fx3_q),
    .fy_i           (fy3_q),
    .map_present_i  (map_present_q),
    .object_alpha_i (object_alpha_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .alpha_o        (alpha_o)
  );

endmodule

// ===== test/bats_alpha_checker.sv =====
// Checker for the alpha sampler: mirrors the registers and texels, predicts and compares.
`timescale 1ns / 1ps

module bats_alpha_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [bats_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bats_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic                                mode_i,
  input  logic [bats_pkg::TEX_IDX_W-1:0]      texel_index_i,
  input  logic [bats_pkg::TEX_VAL_W-1:0]      texel_value_i,
  input  logic signed [bats_pkg::COORD_W-1:0] coord_u_i,
  input  logic signed [bats_pkg::COORD_W-1:0] coord_v_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [bats_pkg::ALPHA_W-1:0]        alpha_i,
  output int                                  mismatch_count_o,
  output int                                  pending_o,
  output int                                  checked_o
);
  import bats_pkg::*;

  localparam int ONE_Q     = 1 << 16;
  localparam int SIDE_MAX  = 256;
  localparam int PRINT_MAX = 20;

  // Shadow of the registers and the texel store
  logic                 map_on;
  logic [8:0]           width_reg;
  logic [8:0]           height_reg;
  logic [ALPHA_W-1:0]   fallback_alpha;
  logic [TEX_VAL_W-1:0] texel_mem [0:65535];

  // Alphas owed by the block, oldest first
  logic [ALPHA_W-1:0]   owed_alphas [$];
  logic [ALPHA_W-1:0]   want_alpha;

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
    checked_o        = 0;
  end

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatch_count_o++;
    if (mismatch_count_o <= PRINT_MAX) begin
      $display("%0t ns  mismatch: %s  got %h  want %h", $time, what, got, want);
    end
  endtask

  function automatic logic [8:0] used_dim(logic [8:0] d);
    if (d == 9'd0) return 9'd1;
    if (d > SIDE_MAX) return 9'(SIDE_MAX);
    return d;
  endfunction

  // Clamp a signed coordinate to zero..one
  function automatic logic [16:0] clamp_coord(logic signed [18:0] c);
    if (c < 0) return 17'd0;
    if (c > ONE_Q) return 17'(ONE_Q);
    return c[16:0];
  endfunction

  // Floor and ceiling texel on one axis, plus the fraction between them
  function automatic void locate(input logic [16:0] c, input logic [8:0] dim,
                                 output logic [7:0] lo, output logic [7:0] hi,
                                 output logic [16:0] frac);
    logic [31:0] pos;
    logic [31:0] f0;
    logic [31:0] f1;
    pos  = 32'(c) * (32'(dim) - 32'd1);
    f0   = pos >> 16;
    frac = {1'b0, pos[15:0]};
    f1   = f0 + ((pos[15:0] != 16'd0) ? 32'd1 : 32'd0);
    if (f0 > 32'(dim) - 32'd1) f0 = 32'(dim) - 32'd1;
    if (f1 > 32'(dim) - 32'd1) f1 = 32'(dim) - 32'd1;
    // on a texel the weights collapse to one and zero
    if (f1 == f0) frac = 17'd0;
    lo = f0[7:0];
    hi = f1[7:0];
  endfunction

  function automatic logic [31:0] blend(logic [31:0] t0, logic [31:0] t1, logic [16:0] frac);
    logic [63:0] acc;
    acc = (64'(ONE_Q) - 64'(frac)) * 64'(t0) + 64'(frac) * 64'(t1) + 64'(ONE_Q / 2);
    return 32'(acc >> 16);
  endfunction

  function automatic logic [31:0] texel_at(logic [7:0] x, logic [7:0] y, logic [8:0] w);
    logic [31:0] addr;
    addr = 32'(y) * 32'(w) + 32'(x);
    return 32'(texel_mem[addr[15:0]]);
  endfunction

  // Alpha the block must return for a sample at (u, v)
  function automatic logic [15:0] filtered_alpha(logic signed [18:0] u, logic signed [18:0] v);
    logic [8:0]  w;
    logic [8:0]  h;
    logic [7:0]  x0;
    logic [7:0]  x1;
    logic [7:0]  y0;
    logic [7:0]  y1;
    logic [16:0] fx;
    logic [16:0] fy;
    logic [31:0] upper;
    logic [31:0] lower;
    logic [31:0] mix;
    if (!map_on) return fallback_alpha;
    w = used_dim(width_reg);
    h = used_dim(height_reg);
    locate(clamp_coord(u), w, x0, x1, fx);
    locate(clamp_coord(v), h, y0, y1, fy);
    upper = blend(texel_at(x0, y0, w), texel_at(x1, y0, w), fx);
    lower = blend(texel_at(x0, y1, w), texel_at(x1, y1, w), fx);
    mix   = blend(upper, lower, fy);
    return (mix > 32'hFFFF) ? 16'hFFFF : mix[15:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_on         = 1'b0;
      width_reg      = 9'd1;
      height_reg     = 9'd1;
      fallback_alpha = 16'hFFFF;
      owed_alphas.delete();
    end else begin
      // Track register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MAP_PRESENT:  map_on         = cfg_data_i[0];
          CFG_TEX_WIDTH:    width_reg      = cfg_data_i[8:0];
          CFG_TEX_HEIGHT:   height_reg     = cfg_data_i[8:0];
          CFG_OBJECT_ALPHA: fallback_alpha = cfg_data_i;
          default: ;
        endcase
      end
      // Compare each result word with the oldest owed alpha
      if (out_valid_i && !out_stall_i) begin
        if (owed_alphas.size() == 0) begin
          report_mismatch("alpha word with none owed", alpha_i, 16'h0000);
        end else begin
          want_alpha = owed_alphas.pop_front();
          checked_o++;
          if (alpha_i !== want_alpha) report_mismatch("alpha", alpha_i, want_alpha);
        end
      end
      // Store texels, queue alphas for samples
      if (in_valid_i && !in_stall_i) begin
        if (mode_i == MODE_SAMPLE) begin
          owed_alphas.push_back(filtered_alpha(coord_u_i, coord_v_i));
        end else begin
          texel_mem[texel_index_i] = texel_value_i;
        end
      end
    end
    pending_o <= owed_alphas.size();
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench top: drives the alpha sampler with texel writes and samples, gives the verdict.
`timescale 1ns / 1ps

module tb_top;
  import bats_pkg::*;

  localparam int ONE_Q    = 1 << 16;
  localparam int SIDE_MAX = 256;
  localparam int PHASES   = 12;
  localparam int PER_PHASE = 160;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_e;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = CFG_MAP_PRESENT;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       mode = MODE_WRITE;
  logic [TEX_IDX_W-1:0]       texel_index = '0;
  logic [TEX_VAL_W-1:0]       texel_value = '0;
  logic signed [COORD_W-1:0]  coord_u = '0;
  logic signed [COORD_W-1:0]  coord_v = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [ALPHA_W-1:0]         alpha;

  int mismatches;
  int pending;
  int checked;

  bilinear_alpha_texture_sampler_core u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .mode_i        (mode),
    .texel_index_i (texel_index),
    .texel_value_i (texel_value),
    .coord_u_i     (coord_u),
    .coord_v_i     (coord_v),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .alpha_o       (alpha)
  );

  bats_alpha_checker u_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .mode_i           (mode),
    .texel_index_i    (texel_index),
    .texel_value_i    (texel_value),
    .coord_u_i        (coord_u),
    .coord_v_i        (coord_v),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .alpha_i          (alpha),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    #10_000_000;
    $display("FAIL bilinear_alpha_texture_sampler_core");
    $finish;
  end

  // Receiver: stall on a style drawn at random from none, light, heavy and periodic
  stall_style_e stall_style = STALL_NONE;
  int           cyc = 0;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 256 == 0) stall_style <= stall_style_e'($urandom_range(0, 3));
    case (stall_style)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((cyc % 7) < 3);
    endcase
  end

  // Sender state and a mirror of what has been written
  bit         texel_written [0:65535];
  int         burst_left = 0;
  int         samples_sent = 0;
  int         writes_sent = 0;
  int         configs_run = 0;
  logic       map_cfg = 1'b0;
  int         w_cfg = 1;
  int         h_cfg = 1;

  function automatic logic [15:0] texel_pick();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly in range, some on texels, some anywhere in the signed field
  function automatic logic signed [18:0] sample_coord();
    int k;
    k = $urandom_range(0, 4);
    case ($urandom_range(0, 9))
      0:       return 19'sd0;
      1:       return 19'(ONE_Q);
      2:       return 19'(k * ONE_Q / 4);
      3, 4:    return 19'($urandom);
      default: return 19'($urandom_range(0, ONE_Q));
    endcase
  endfunction

  function automatic logic [8:0] pick_dim();
    case ($urandom_range(0, 11))
      0:       return 9'(SIDE_MAX);
      1:       return 9'($urandom_range(SIDE_MAX + 1, 511));
      2:       return 9'd0;
      3:       return 9'd1;
      default: return 9'($urandom_range(2, 16));
    endcase
  endfunction

  function automatic int first_texel(logic signed [18:0] c, int dim);
    int cc;
    cc = (c < 0) ? 0 : (c > ONE_Q) ? ONE_Q : int'(c);
    return (cc * (dim - 1)) >> 16;
  endfunction

  // Send one input word, opening a new burst after a random gap
  task automatic issue_word(logic m, logic [15:0] idx, logic [15:0] val,
                            logic signed [18:0] u, logic signed [18:0] v);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    mode        <= m;
    texel_index <= idx;
    texel_value <= val;
    coord_u     <= u;
    coord_v     <= v;
    do @(posedge clk); while (in_stall);
    if (m == MODE_WRITE) begin
      texel_written[idx] = 1'b1;
      writes_sent++;
    end else begin
      samples_sent++;
    end
  endtask

  task automatic put_texel(int addr, logic [15:0] val);
    issue_word(MODE_WRITE, 16'(addr), val, 19'($urandom), 19'($urandom));
  endtask

  // With a map on, load any of the four texels a sample would read that are still unwritten; then send the sample
  task automatic sample_at(logic signed [18:0] u, logic signed [18:0] v);
    int xs [2];
    int ys [2];
    int i;
    int j;
    int addr;
    if (map_cfg) begin
      xs[0] = first_texel(u, w_cfg);
      xs[1] = (xs[0] + 1 < w_cfg) ? xs[0] + 1 : xs[0];
      ys[0] = first_texel(v, h_cfg);
      ys[1] = (ys[0] + 1 < h_cfg) ? ys[0] + 1 : ys[0];
      for (j = 0; j < 2; j++) begin
        for (i = 0; i < 2; i++) begin
          addr = ys[j] * w_cfg + xs[i];
          if (!texel_written[addr]) put_texel(addr, texel_pick());
        end
      end
    end
    issue_word(MODE_SAMPLE, 16'($urandom), 16'($urandom), u, v);
  endtask

  // Drop valid, wait for every owed alpha, then let the pipeline empty
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Write all four registers on an idle block, then one unmapped index
  task automatic write_config(logic map, logic [8:0] w, logic [8:0] h, logic [15:0] obj);
    logic [CFG_IDX_W-1:0]  ids [4];
    logic [CFG_DATA_W-1:0] words [4];
    int r;
    ids[0]   = CFG_MAP_PRESENT;
    ids[1]   = CFG_TEX_WIDTH;
    ids[2]   = CFG_TEX_HEIGHT;
    ids[3]   = CFG_OBJECT_ALPHA;
    // upper bits beyond a register's width are junk now and then
    words[0] = {($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'd0, map};
    words[1] = {($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'd0, w};
    words[2] = {($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'd0, h};
    words[3] = obj;
    settle();
    for (r = 0; r < 5; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (r < 4) ? ids[r] : CFG_IDX_W'($urandom_range(CFG_OBJECT_ALPHA + 1, 15));
      cfg_data  <= (r < 4) ? words[r] : CFG_DATA_W'($urandom);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    map_cfg = map;
    w_cfg   = (w == 0) ? 1 : (w > SIDE_MAX) ? SIDE_MAX : int'(w);
    h_cfg   = (h == 0) ? 1 : (h > SIDE_MAX) ? SIDE_MAX : int'(h);
    configs_run++;
  endtask

  initial begin
    int a;
    int ph;
    int base;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: no map, so samples give the object alpha; writes still land
    put_texel(0, 16'hBEEF);
    put_texel(65535, 16'hFFFF);
    put_texel(1, 16'h0000);
    sample_at(19'sd0, 19'sd0);
    sample_at(19'(-262144), 19'sd262143);

    // One texel: every coordinate lands on it
    write_config(1'b1, 9'd1, 9'd1, 16'h1234);
    sample_at(19'(ONE_Q / 2), -19'sd1);
    sample_at(19'sd262143, 19'sd0);

    // Three by three: corners, exact texel hits, fractions, out of range
    write_config(1'b1, 9'd3, 9'd3, 16'h0000);
    for (a = 0; a < 9; a++) put_texel(a, (a == 4) ? 16'h0000 : (a == 5) ? 16'hFFFF : texel_pick());
    sample_at(19'sd0, 19'sd0);
    sample_at(19'(ONE_Q), 19'(ONE_Q));
    sample_at(19'(ONE_Q / 2), 19'(ONE_Q));
    sample_at(19'sd10000, 19'sd40000);
    sample_at(-19'sd5, 19'sd70000);

    // Zero sizes act as one, oversized as the largest side
    write_config(1'b1, 9'd0, 9'd0, 16'hFFFF);
    sample_at(19'sd30000, 19'sd50000);
    write_config(1'b1, 9'd511, 9'd300, 16'hFFFF);
    sample_at(19'(ONE_Q), 19'(ONE_Q));
    sample_at(19'(ONE_Q / 2), 19'(ONE_Q / 3));
    write_config(1'b0, 9'(SIDE_MAX), 9'(SIDE_MAX), 16'h0000);
    sample_at(19'sd1234, 19'sd5678);

    // Random settings, each with a fixed budget of texel writes and samples
    for (ph = 0; ph < PHASES; ph++) begin
      write_config($urandom_range(0, 7) != 0, pick_dim(), pick_dim(),
                   ($urandom_range(0, 3) == 0) ? 16'h0000 :
                   ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom));
      base = samples_sent + writes_sent;
      while (samples_sent + writes_sent - base < PER_PHASE) begin
        case ($urandom_range(0, 9))
          0, 1, 2: put_texel($urandom_range(0, h_cfg - 1) * w_cfg + $urandom_range(0, w_cfg - 1),
                             texel_pick());
          3:       put_texel($urandom_range(0, 65535), texel_pick());
          default: sample_at(sample_coord(), sample_coord());
        endcase
      end
    end

    settle();
    $display("Covered %0d samples and %0d texel writes over %0d register settings.",
             samples_sent, writes_sent, configs_run);
    $display("Compared %0d alpha words, %0d mismatched.", checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS bilinear_alpha_texture_sampler_core");
    end else begin
      $display("FAIL bilinear_alpha_texture_sampler_core");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bats_pkg.sv
rtl/bats_ram.sv
rtl/bats_addr.sv
rtl/bats_filter.sv
rtl/bilinear_alpha_texture_sampler_core.sv
test/bats_alpha_checker.sv
test/tb_top.sv
